// ----- hdl/fit_block_allocator_macros.svh -----
// Assertion macros for the fit block allocator.
`ifndef FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FBA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fit block allocator assertion failed");
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fit block allocator assertion failed");
`else
`define FBA_ASSERT_SAME(label, clk, rst, ante, cons)
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/fba_pkg.sv -----
// Shared types and constants for the fit block allocator.
`default_nettype none
package fba_pkg;

  localparam int NUM_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 16;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int CFG_W    = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_ALT   = 2'd3
  } fit_mode_t;

  typedef enum logic {
    CFG_FIT_MODE      = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic      start;
    logic      cand_valid;
    fit_mode_t mode;
  } pick_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/fba_pick_unit.sv -----
// Compare and select unit that keeps the candidate block of a scan chosen by the fit mode.
`default_nettype none
module fba_pick_unit import fba_pkg::*; #(
  parameter int IDX_W     = 5,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pick_ctl_t            ctl,
  input  wire logic [IDX_W-1:0]     cand_index,
  input  wire logic [SIZE_BITS-1:0] cand_size,
  input  wire logic                 cand_used,
  input  wire logic [SIZE_BITS-1:0] want,
  output logic                      pick_found,
  output logic [IDX_W-1:0]          pick_index,
  output logic [SIZE_BITS-1:0]      pick_size
);

  logic fits;
  logic better;

  assign fits = !cand_used && (cand_size >= want);

  always_comb begin
    case (ctl.mode)
      MODE_BEST:  better = cand_size < pick_size;
      MODE_WORST: better = cand_size > pick_size;
      default:    better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_found <= 1'b0;
    end else if (ctl.start) begin
      pick_found <= 1'b0;
    end else if (ctl.cand_valid && fits && (!pick_found || better)) begin
      pick_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cand_valid && fits && (!pick_found || better)) begin
      pick_index <= cand_index;
      pick_size  <= cand_size;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fit_block_allocator.sv -----
// Top level of the fit block allocator with table memory and scan sequencer.
`default_nettype none
`include "fit_block_allocator_macros.svh"
// The block holds a table of block sizes in a memory with one write port and one read port,
// with one used flag per block. Load and clear items are taken in the idle state and give no
// result. An allocate item scans the first blocks_in_use entries (saturated to NUM_BLOCKS)
// one entry per cycle through the memory read port and one shared compare unit, and keeps
// the block busy until its result is registered; when no entry takes part it skips the scan.
// A finished result sits in an output register, and the next item is accepted while
// it waits to be taken; a scan that ends while that register is still full waits, and the
// input stays stalled until the register is free.
module fit_block_allocator import fba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [REQ_W-1:0]   req_type,
  input  wire logic [INDEX_W-1:0] block_index,
  input  wire logic [VALUE_W-1:0] size_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found,
  output logic [INDEX_W-1:0]      chosen_index,
  output logic [VALUE_W-1:0]      chosen_size
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int LIM_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
  localparam int EXT_W = (LIM_W > INDEX_W) ? LIM_W : INDEX_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                state;
  fit_mode_t             fit_mode;
  logic [COUNT_W-1:0]    blocks_in_use;
  logic [NUM_BLOCKS-1:0] used;
  logic [SIZE_BITS-1:0]  size_ram [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  rd_data;
  logic [SIZE_BITS-1:0]  want;
  logic [IDX_W-1:0]      addr;
  logic [IDX_W-1:0]      last_idx;
  logic                  issue_done;
  logic                  cand_valid;
  logic [IDX_W-1:0]      cand_index;

  logic                  accept;
  req_t                  req;
  logic [SIZE_BITS-1:0]  size_in;
  logic [EXT_W-1:0]      bidx_ext;
  logic                  load_ok;
  logic [CMP_W-1:0]      bu_ext;
  logic [LIM_W-1:0]      lim_sat;
  logic                  out_free;

  pick_ctl_t             ctl;
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_index;
  logic [SIZE_BITS-1:0]  pick_size;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign req      = req_t'(req_type);
  assign size_in  = SIZE_BITS'(size_value);
  assign bidx_ext = EXT_W'(block_index);
  assign load_ok  = accept && (req == REQ_LOAD) && (bidx_ext < EXT_W'(NUM_BLOCKS));
  assign bu_ext   = CMP_W'(blocks_in_use);
  assign lim_sat  = (bu_ext > CMP_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : LIM_W'(bu_ext);
  assign out_free = !out_valid || !out_stall;

  assign ctl.start      = accept && (req == REQ_ALLOC);
  assign ctl.cand_valid = cand_valid;
  assign ctl.mode       = fit_mode;

  always_ff @(posedge clk) begin
    if (load_ok) begin
      size_ram[bidx_ext[IDX_W-1:0]] <= size_in;
    end
    rd_data <= size_ram[addr];
  end

  fba_pick_unit #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cand_index (cand_index),
    .cand_size  (rd_data),
    .cand_used  (used[cand_index]),
    .want       (want),
    .pick_found (pick_found),
    .pick_index (pick_index),
    .pick_size  (pick_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fit_mode      <= MODE_FIRST;
      blocks_in_use <= '0;
      used          <= '0;
      out_valid     <= 1'b0;
      issue_done    <= 1'b0;
      cand_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FIT_MODE:      fit_mode <= fit_mode_t'(cfg_data[MODE_W-1:0]);
          CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[COUNT_W-1:0];
          default:           ;
        endcase
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      cand_valid <= (state == ST_SCAN) && !issue_done;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req)
              REQ_CLEAR: used <= '0;
              REQ_ALLOC: begin
                issue_done <= 1'b0;
                state      <= (lim_sat == '0) ? ST_DONE : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!issue_done && (addr == last_idx)) begin
            issue_done <= 1'b1;
          end
          if (cand_valid && (cand_index == last_idx)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (pick_found) begin
              used[pick_index] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cand_index <= addr;
    if (ctl.start) begin
      want     <= size_in;
      addr     <= '0;
      last_idx <= IDX_W'(lim_sat - LIM_W'(1));
    end else if ((state == ST_SCAN) && !issue_done) begin
      addr <= addr + IDX_W'(1);
    end
    if ((state == ST_DONE) && out_free) begin
      found        <= pick_found;
      chosen_index <= pick_found ? INDEX_W'(pick_index) : '0;
      chosen_size  <= pick_found ? VALUE_W'(pick_size) : '0;
    end
  end

  `FBA_ASSERT_SAME(a_cand_in_scan, clk, rst, cand_valid, state == ST_SCAN)
  `FBA_ASSERT_NEXT(a_done_delivers, clk, rst, (state == ST_DONE) && out_free,
                   (state == ST_IDLE) && out_valid)
  `FBA_ASSERT_SAME(a_miss_is_zero, clk, rst, out_valid && !found,
                   (chosen_index == '0) && (chosen_size == '0))
  `FBA_ASSERT_SAME(a_pick_fits, clk, rst, pick_found, pick_size >= want)

endmodule
`default_nettype wire
